/* hdl/rci_pkg.sv */
// shared types, constants and saturating fixed-point helpers for the ray/cone tester
`timescale 1ns / 1ps
`default_nettype none
package rci_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic signed [31:0] QMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;

  // register indexes on the config port
  localparam logic [2:0] REG_BASE_X = 3'd0;
  localparam logic [2:0] REG_BASE_Y = 3'd1;
  localparam logic [2:0] REG_BASE_Z = 3'd2;
  localparam logic [2:0] REG_RADIUS = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  typedef enum logic [1:0] {
    K_IDLE,
    K_START,
    K_DIV,
    K_SQR
  } k_state_e;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [31:0] tlo;
    logic signed [31:0] thi;
  } ray_t;

  typedef struct packed {
    logic               vld;
    logic               root;
    logic signed [31:0] nb;
    logic signed [31:0] den;
    ray_t               ray;
  } sq_side_t;

  typedef struct packed {
    logic vld;
    logic root;
    ray_t ray;
  } dt_side_t;

  typedef struct packed {
    logic               vld;
    logic               hit;
    logic signed [31:0] t;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } dn_side_t;

  function automatic logic signed [31:0] qsat(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return QMAX;
    end else if (v < -66'sd2147483648) begin
      return QMIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return qsat(66'(a) + 66'(b));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return qsat(66'(a) - 66'(b));
  endfunction

  // product rounded toward minus infinity
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input int frac);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return qsat(66'(p >>> frac));
  endfunction

endpackage
`default_nettype wire

/* hdl/rci_sqrt_pipe.sv */
// pipelined floor square root of a nonnegative fixed-point value, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module rci_sqrt_pipe #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic [30:0] rad_i,
  output logic      [31:0] root_o
);
  localparam int NW = 31 + FRAC_BITS;
  localparam int R  = (NW + 1) / 2;
  localparam int W2 = 2 * R;
  localparam int RW = R + 2;

  logic [W2-1:0] n_q    [R+1];
  logic [RW-1:0] rem_q  [R+1];
  logic [R-1:0]  root_q [R+1];

  always_ff @(posedge clk_i) begin
    n_q[0]    <= W2'({rad_i, {FRAC_BITS{1'b0}}});
    rem_q[0]  <= '0;
    root_q[0] <= '0;
  end

  for (genvar s = 0; s < R; s++) begin : g_step
    logic [RW-1:0] trem;
    logic [RW-1:0] trial;
    logic          ge;
    assign trem  = {rem_q[s][RW-3:0], n_q[s][W2-1:W2-2]};
    assign trial = {root_q[s], 2'b01};
    assign ge    = trem >= trial;
    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= ge ? (trem - trial) : trem;
      root_q[s+1] <= {root_q[s][R-2:0], ge};
      n_q[s+1]    <= {n_q[s][W2-3:0], 2'b00};
    end
  end

  assign root_o = 32'(root_q[R]);

endmodule
`default_nettype wire

/* hdl/rci_div_pipe.sv */
// pipelined saturating fixed-point divider, truncating toward zero, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module rci_div_pipe #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic signed [31:0] den_i,
  output logic signed      [31:0] quo_o
);
  import rci_pkg::*;

  localparam int QW = 32 + FRAC_BITS;

  logic [31:0]    rem_q  [QW+1];
  logic [QW-1:0]  nsh_q  [QW+1];
  logic [QW-1:0]  quo_q  [QW+1];
  logic [31:0]    dm_q   [QW+1];
  logic           neg_q  [QW+1];
  logic           dz_q   [QW+1];
  logic           nneg_q [QW+1];
  logic [31:0]    nmag;
  logic [31:0]    dmag;
  logic [QW-1:0]  qf;
  logic signed [31:0] res;

  assign nmag = num_i[31] ? (~num_i + 32'd1) : num_i;
  assign dmag = den_i[31] ? (~den_i + 32'd1) : den_i;

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    quo_q[0]  <= '0;
    nsh_q[0]  <= {nmag, {FRAC_BITS{1'b0}}};
    dm_q[0]   <= dmag;
    neg_q[0]  <= num_i[31] ^ den_i[31];
    dz_q[0]   <= den_i == 32'sd0;
    nneg_q[0] <= num_i[31];
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem_q[s], nsh_q[s][QW-1]};
    assign ge    = trial >= {1'b0, dm_q[s]};
    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= ge ? 32'(trial - {1'b0, dm_q[s]}) : trial[31:0];
      nsh_q[s+1]  <= {nsh_q[s][QW-2:0], 1'b0};
      quo_q[s+1]  <= {quo_q[s][QW-2:0], ge};
      dm_q[s+1]   <= dm_q[s];
      neg_q[s+1]  <= neg_q[s];
      dz_q[s+1]   <= dz_q[s];
      nneg_q[s+1] <= nneg_q[s];
    end
  end

  assign qf = quo_q[QW];

  always_comb begin
    if (dz_q[QW]) begin
      res = nneg_q[QW] ? QMIN : QMAX;
    end else if (neg_q[QW]) begin
      if ((|qf[QW-1:32]) || (qf[31] && (|qf[30:0]))) begin
        res = QMIN;
      end else begin
        res = ~qf[31:0] + 32'd1;
      end
    end else if (|qf[QW-1:31]) begin
      res = QMAX;
    end else begin
      res = qf[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_o <= res;
  end

endmodule
`default_nettype wire

/* hdl/ray_cone_intersect_unit.sv */
// top level: config registers, slope factor sequencer and the ray/cone test pipeline
// throughput: one ray per cycle while busy is low, set by the fully pipelined root and divider chains
// busy is high after a radius or height write while the slope factor is recomputed
//   by a bit-serial divider; results cannot be held off
// reset: asynchronous, active low; clears all valid bits, config to base 0, radius and height 1.0
`timescale 1ns / 1ps
`default_nettype none
module ray_cone_intersect_unit #(
  parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // config port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // ray beat
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] orig_x_i,
  input  wire logic signed [31:0] orig_y_i,
  input  wire logic signed [31:0] orig_z_i,
  input  wire logic signed [31:0] dir_x_i,
  input  wire logic signed [31:0] dir_y_i,
  input  wire logic signed [31:0] dir_z_i,
  input  wire logic signed [31:0] t_min_i,
  input  wire logic signed [31:0] t_max_i,
  // result beat
  output logic                    valid_o,
  output logic                    hit_o,
  output logic signed      [31:0] t_hit_o,
  output logic signed      [31:0] point_x_o,
  output logic signed      [31:0] point_y_o,
  output logic signed      [31:0] point_z_o,
  output logic signed      [31:0] normal_x_o,
  output logic signed      [31:0] normal_y_o,
  output logic signed      [31:0] normal_z_o
);
  import rci_pkg::*;

  localparam int R   = (32 + FRAC_BITS) / 2;
  localparam int SQ  = R + 1;            // root latency
  localparam int DV  = 34 + FRAC_BITS;   // divider latency
  localparam int LAT = 13 + SQ + 2 * DV;
  localparam int KNW = 31 + FRAC_BITS;
  localparam int KCW = $clog2(KNW);
  localparam logic signed [31:0] QONE = 32'sd1 <<< FRAC_BITS;

  // ---------------------------------------------------------------- config registers
  logic signed [31:0] base_x_q, base_y_q, base_z_q;
  logic [30:0]        radius_q, height_q;
  logic               wr;
  logic [2:0]         widx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign widx   = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q <= '0;
      base_y_q <= '0;
      base_z_q <= '0;
      radius_q <= 31'(QONE);
      height_q <= 31'(QONE);
    end else if (wr) begin
      case (widx)
        REG_BASE_X: base_x_q <= pwdata;
        REG_BASE_Y: base_y_q <= pwdata;
        REG_BASE_Z: base_z_q <= pwdata;
        REG_RADIUS: radius_q <= pwdata[30:0];
        REG_HEIGHT: height_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_BASE_X: prdata = base_x_q;
      REG_BASE_Y: prdata = base_y_q;
      REG_BASE_Z: prdata = base_z_q;
      REG_RADIUS: prdata = {1'b0, radius_q};
      REG_HEIGHT: prdata = {1'b0, height_q};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- slope factor k
  // k = (radius / height)^2, recomputed bit-serially after a radius or height write
  k_state_e           k_st_q, k_st_d;
  logic [31:0]        krem_q;
  logic [KNW-1:0]     knum_q, kquo_q;
  logic [KCW-1:0]     kcnt_q;
  logic signed [31:0] k_q;
  logic               geo_wr;
  logic [32:0]        ktrial;
  logic               kge;
  logic signed [31:0] kq;

  assign geo_wr = wr && (widx == REG_RADIUS || widx == REG_HEIGHT);
  assign ktrial = {krem_q, knum_q[KNW-1]};
  assign kge    = ktrial >= {2'b00, height_q};
  assign kq     = (height_q == 31'd0 || (|kquo_q[KNW-1:31])) ? QMAX
                                                             : {1'b0, kquo_q[30:0]};

  always_comb begin
    k_st_d = k_st_q;
    case (k_st_q)
      K_IDLE:  k_st_d = K_IDLE;
      K_START: k_st_d = K_DIV;
      K_DIV:   k_st_d = (kcnt_q == '0) ? K_SQR : K_DIV;
      K_SQR:   k_st_d = K_IDLE;
      default: k_st_d = K_IDLE;
    endcase
    if (geo_wr) begin
      k_st_d = K_START;
    end
    busy = k_st_q != K_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_st_q <= K_IDLE;
    end else begin
      k_st_q <= k_st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= QONE;
    end else if (k_st_q == K_SQR) begin
      k_q <= qmul(kq, kq, FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    case (k_st_q)
      K_START: begin
        krem_q <= '0;
        kquo_q <= '0;
        knum_q <= {radius_q, {FRAC_BITS{1'b0}}};
        kcnt_q <= KCW'(KNW - 1);
      end
      K_DIV: begin
        krem_q <= kge ? 32'(ktrial - {2'b00, height_q}) : ktrial[31:0];
        kquo_q <= {kquo_q[KNW-2:0], kge};
        knum_q <= {knum_q[KNW-2:0], 1'b0};
        kcnt_q <= kcnt_q - KCW'(1);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- pipeline
  logic accept;
  assign accept = start & ~busy;

  logic [6:1] v_q;   // valid bits of stages 1..6
  ray_t s1_ray_q, s2_ray_q, s3_ray_q, s4_ray_q, s5_ray_q, s6_ray_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[5:1], accept};
    end
  end

  // stage 1: capture the beat
  always_ff @(posedge clk_i) begin
    s1_ray_q <= '{ox: orig_x_i, oy: orig_y_i, oz: orig_z_i,
                  dx: dir_x_i, dy: dir_y_i, dz: dir_z_i,
                  tlo: t_min_i, thi: t_max_i};
  end

  // stage 2: origin relative to the base, and to the apex in y
  logic signed [31:0] s2_cx_q, s2_cz_q, s2_cyh_q;
  always_ff @(posedge clk_i) begin
    s2_ray_q <= s1_ray_q;
    s2_cx_q  <= qsub(s1_ray_q.ox, base_x_q);
    s2_cz_q  <= qsub(s1_ray_q.oz, base_z_q);
    s2_cyh_q <= qsub(qsub(s1_ray_q.oy, base_y_q), $signed({1'b0, height_q}));
  end

  // stage 3: first products
  logic signed [31:0] s3_dxdx_q, s3_dzdz_q, s3_kdy_q, s3_dxcx_q, s3_dzcz_q;
  logic signed [31:0] s3_kcyh_q, s3_cxcx_q, s3_czcz_q, s3_cyh_q;
  always_ff @(posedge clk_i) begin
    s3_ray_q  <= s2_ray_q;
    s3_cyh_q  <= s2_cyh_q;
    s3_dxdx_q <= qmul(s2_ray_q.dx, s2_ray_q.dx, FRAC_BITS);
    s3_dzdz_q <= qmul(s2_ray_q.dz, s2_ray_q.dz, FRAC_BITS);
    s3_kdy_q  <= qmul(k_q, s2_ray_q.dy, FRAC_BITS);
    s3_dxcx_q <= qmul(s2_ray_q.dx, s2_cx_q, FRAC_BITS);
    s3_dzcz_q <= qmul(s2_ray_q.dz, s2_cz_q, FRAC_BITS);
    s3_kcyh_q <= qmul(k_q, s2_cyh_q, FRAC_BITS);
    s3_cxcx_q <= qmul(s2_cx_q, s2_cx_q, FRAC_BITS);
    s3_czcz_q <= qmul(s2_cz_q, s2_cz_q, FRAC_BITS);
  end

  // stage 4: cone terms and radial sums
  logic signed [31:0] s4_ka_q, s4_kb_q, s4_kc_q, s4_sa_q, s4_sb_q, s4_sc_q;
  always_ff @(posedge clk_i) begin
    s4_ray_q <= s3_ray_q;
    s4_ka_q  <= qmul(s3_kdy_q, s3_ray_q.dy, FRAC_BITS);
    s4_kb_q  <= qmul(s3_kdy_q, s3_cyh_q, FRAC_BITS);
    s4_kc_q  <= qmul(s3_kcyh_q, s3_cyh_q, FRAC_BITS);
    s4_sa_q  <= qadd(s3_dxdx_q, s3_dzdz_q);
    s4_sb_q  <= qadd(s3_dxcx_q, s3_dzcz_q);
    s4_sc_q  <= qadd(s3_cxcx_q, s3_czcz_q);
  end

  // stage 5: quadratic coefficients
  logic signed [31:0] s5_a_q, s5_b_q, s5_c_q, s5_bh;
  assign s5_bh = qsub(s4_sb_q, s4_kb_q);
  always_ff @(posedge clk_i) begin
    s5_ray_q <= s4_ray_q;
    s5_a_q   <= qsub(s4_sa_q, s4_ka_q);
    s5_b_q   <= qsat(66'(s5_bh) + 66'(s5_bh));
    s5_c_q   <= qsub(s4_sc_q, s4_kc_q);
  end

  // stage 6: discriminant products
  logic signed [31:0] s6_bb_q, s6_ac_q, s6_a_q, s6_b_q, s6_a4;
  assign s6_a4 = qsat(66'(s5_a_q) <<< 2);
  always_ff @(posedge clk_i) begin
    s6_ray_q <= s5_ray_q;
    s6_a_q   <= s5_a_q;
    s6_b_q   <= s5_b_q;
    s6_bb_q  <= qmul(s5_b_q, s5_b_q, FRAC_BITS);
    s6_ac_q  <= qmul(s6_a4, s5_c_q, FRAC_BITS);
  end

  // stage 7: discriminant, -b and 2a; a root exists only for disc >= 0 and a != 0
  logic signed [31:0] s7_disc;
  logic [30:0]        s7_rad_q;
  sq_side_t           sq_dl_q [SQ+1];
  logic               s7_root;
  assign s7_disc = qsub(s6_bb_q, s6_ac_q);
  assign s7_root = !s7_disc[31] && (s6_a_q != 32'sd0);

  always_ff @(posedge clk_i) begin
    s7_rad_q <= s7_disc[31] ? 31'd0 : s7_disc[30:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_dl_q[0] <= '0;
    end else begin
      sq_dl_q[0] <= '{vld: v_q[6], root: s7_root, nb: qsat(-66'(s6_b_q)),
                     den: qsat(66'(s6_a_q) + 66'(s6_a_q)), ray: s6_ray_q};
    end
  end

  for (genvar i = 1; i <= SQ; i++) begin : g_sq_dl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_dl_q[i] <= '0;
      end else begin
        sq_dl_q[i] <= sq_dl_q[i-1];
      end
    end
  end

  logic [31:0] sq_root;
  rci_sqrt_pipe #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (s7_rad_q),
    .root_o (sq_root)
  );

  // stage 8: numerators of both roots
  logic signed [31:0] s8_n1_q, s8_n2_q, s8_den_q;
  dt_side_t           dt_dl_q [DV+1];
  always_ff @(posedge clk_i) begin
    s8_n1_q  <= qsub(sq_dl_q[SQ].nb, $signed(sq_root));
    s8_n2_q  <= qadd(sq_dl_q[SQ].nb, $signed(sq_root));
    s8_den_q <= sq_dl_q[SQ].den;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_dl_q[0] <= '0;
    end else begin
      dt_dl_q[0] <= '{vld: sq_dl_q[SQ].vld, root: sq_dl_q[SQ].root, ray: sq_dl_q[SQ].ray};
    end
  end

  for (genvar i = 1; i <= DV; i++) begin : g_dt_dl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dt_dl_q[i] <= '0;
      end else begin
        dt_dl_q[i] <= dt_dl_q[i-1];
      end
    end
  end

  logic signed [31:0] t_near, t_far;
  rci_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_near (
    .clk_i (clk_i),
    .num_i (s8_n1_q),
    .den_i (s8_den_q),
    .quo_o (t_near)
  );
  rci_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_far (
    .clk_i (clk_i),
    .num_i (s8_n2_q),
    .den_i (s8_den_q),
    .quo_o (t_far)
  );

  // stage 9: near root if in range, else far root
  ray_t               dray;
  logic               in_near, in_far;
  logic               s9_vld_q, s9_ok_q;
  logic signed [31:0] s9_t_q;
  ray_t               s9_ray_q;
  assign dray    = dt_dl_q[DV].ray;
  assign in_near = (t_near >= dray.tlo) && (t_near <= dray.thi);
  assign in_far  = (t_far >= dray.tlo) && (t_far <= dray.thi);

  // stage 10: offsets along the ray
  logic               s10_vld_q, s10_ok_q;
  logic signed [31:0] s10_t_q, s10_tx_q, s10_ty_q, s10_tz_q;
  ray_t               s10_ray_q;
  // stage 11: hit point
  logic               s11_vld_q, s11_ok_q;
  logic signed [31:0] s11_t_q, s11_px_q, s11_py_q, s11_pz_q;
  // stage 12: height band and normal numerators
  logic signed [31:0] s12_nx_q, s12_nz_q, top_y;
  dn_side_t           dn_dl_q [DV+1];
  assign top_y = qadd(base_y_q, $signed({1'b0, height_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      s11_vld_q <= 1'b0;
    end else begin
      s9_vld_q  <= dt_dl_q[DV].vld;
      s10_vld_q <= s9_vld_q;
      s11_vld_q <= s10_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s9_ok_q   <= dt_dl_q[DV].root && (in_near || in_far);
    s9_t_q    <= in_near ? t_near : t_far;
    s9_ray_q  <= dray;
    s10_ok_q  <= s9_ok_q;
    s10_t_q   <= s9_t_q;
    s10_ray_q <= s9_ray_q;
    s10_tx_q  <= qmul(s9_t_q, s9_ray_q.dx, FRAC_BITS);
    s10_ty_q  <= qmul(s9_t_q, s9_ray_q.dy, FRAC_BITS);
    s10_tz_q  <= qmul(s9_t_q, s9_ray_q.dz, FRAC_BITS);
    s11_ok_q  <= s10_ok_q;
    s11_t_q   <= s10_t_q;
    s11_px_q  <= qadd(s10_ray_q.ox, s10_tx_q);
    s11_py_q  <= qadd(s10_ray_q.oy, s10_ty_q);
    s11_pz_q  <= qadd(s10_ray_q.oz, s10_tz_q);
    s12_nx_q  <= qsub(s11_px_q, base_x_q);
    s12_nz_q  <= qsub(s11_pz_q, base_z_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dn_dl_q[0] <= '0;
    end else begin
      dn_dl_q[0] <= '{vld: s11_vld_q,
                     hit: s11_ok_q && !(s11_py_q < base_y_q || s11_py_q > top_y),
                     t: s11_t_q, px: s11_px_q, py: s11_py_q, pz: s11_pz_q};
    end
  end

  for (genvar i = 1; i <= DV; i++) begin : g_dn_dl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dn_dl_q[i] <= '0;
      end else begin
        dn_dl_q[i] <= dn_dl_q[i-1];
      end
    end
  end

  logic signed [31:0] nrm_x, nrm_z;
  rci_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_nx (
    .clk_i (clk_i),
    .num_i (s12_nx_q),
    .den_i ($signed({1'b0, radius_q})),
    .quo_o (nrm_x)
  );
  rci_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_nz (
    .clk_i (clk_i),
    .num_i (s12_nz_q),
    .den_i ($signed({1'b0, radius_q})),
    .quo_o (nrm_z)
  );

  // stage 13: result beat, every field zero on a miss
  dn_side_t dn_out;
  assign dn_out = dn_dl_q[DV];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
      hit_o   <= 1'b0;
    end else begin
      valid_o <= dn_out.vld;
      hit_o   <= dn_out.vld && dn_out.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    t_hit_o    <= dn_out.hit ? dn_out.t  : '0;
    point_x_o  <= dn_out.hit ? dn_out.px : '0;
    point_y_o  <= dn_out.hit ? dn_out.py : '0;
    point_z_o  <= dn_out.hit ? dn_out.pz : '0;
    normal_x_o <= dn_out.hit ? nrm_x     : '0;
    normal_z_o <= dn_out.hit ? nrm_z     : '0;
  end

  assign normal_y_o = '0;

  // ---------------------------------------------------------------- checks
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT valid_o)
    else $error("ray beat did not produce a result at the expected latency");

  a_hit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> valid_o)
    else $error("hit flagged without a result beat");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !hit_o) |-> (t_hit_o == 32'sd0 && point_x_o == 32'sd0 &&
                             point_y_o == 32'sd0 && normal_x_o == 32'sd0))
    else $error("miss result carries nonzero fields");

  a_geo_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    geo_wr |=> busy)
    else $error("radius or height write did not hold off new rays");

endmodule
`default_nettype wire
